// File: rtl/ttip_pkg.sv
package ttip_pkg;

  localparam int unsigned MaxLen     = 65535;
  localparam int unsigned CountW     = 16;
  localparam int unsigned AccW       = 64;
  localparam int unsigned BaseW      = 6;
  localparam int unsigned DigitW     = 6;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  localparam logic [CfgIdxW-1:0] CfgNumberBase = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgResultMode = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgMaxValue   = CfgIdxW'(2);

  localparam logic [ModeW-1:0] ModeRaw      = ModeW'(0);
  localparam logic [ModeW-1:0] ModeSigned   = ModeW'(1);
  localparam logic [ModeW-1:0] ModeUnsigned = ModeW'(2);

  localparam logic [BaseW-1:0]  BaseAuto    = BaseW'(0);
  localparam logic [BaseW-1:0]  BaseOne     = BaseW'(1);
  localparam logic [BaseW-1:0]  BaseMin     = BaseW'(2);
  localparam logic [BaseW-1:0]  BaseOct     = BaseW'(8);
  localparam logic [BaseW-1:0]  BaseDec     = BaseW'(10);
  localparam logic [BaseW-1:0]  BaseHex     = BaseW'(16);
  localparam logic [BaseW-1:0]  BaseMax     = BaseW'(36);
  localparam logic [DigitW-1:0] NotDigit    = '1;
  localparam logic [DigitW-1:0] HexLimit    = DigitW'(16);
  localparam logic [AccW-1:0]   MaxValueRst = {1'b0, {(AccW-1){1'b1}}};

  typedef struct packed {
    logic [7:0] text_byte;
    logic       slice_end;
  } in_word_t;

  typedef struct packed {
    logic [AccW-1:0]   number_out;
    logic [CountW-1:0] bytes_used;
    logic              is_negative;
    logic              did_overflow;
    logic              range_error;
    logic              found_digits;
  } out_word_t;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              is_space;
    logic              is_minus;
    logic              is_plus;
    logic              is_zero;
    logic              is_x;
    logic              last;
  } byte_class_t;

  typedef struct packed {
    logic [AccW-1:0]   value;
    logic [CountW-1:0] used;
    logic              neg;
    logic              ovf;
    logic              found;
  } slice_sum_t;

endpackage

// File: rtl/ttip_front.sv
module ttip_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ttip_pkg::in_word_t    in_word_i,
  input  logic                  full_i,
  output logic                  push_o,
  output ttip_pkg::byte_class_t class_o
);

  logic [7:0] b;
  logic [7:0] lower;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    b     = in_word_i.text_byte;
    lower = b | 8'h20;
    class_o.digit = ttip_pkg::NotDigit;
    if (b >= 8'h30 && b <= 8'h39) begin
      class_o.digit = ttip_pkg::DigitW'(b - 8'h30);
    end else if (lower >= 8'h61 && lower <= 8'h7a) begin
      class_o.digit = ttip_pkg::DigitW'(lower - 8'h57);
    end
    class_o.is_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
    class_o.is_minus = (b == 8'h2d);
    class_o.is_plus  = (b == 8'h2b);
    class_o.is_zero  = (b == 8'h30);
    class_o.is_x     = (lower == 8'h78);
    class_o.last     = in_word_i.slice_end;
  end

endmodule

// File: rtl/ttip_queue.sv
module ttip_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ttip_pkg::byte_class_t data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output ttip_pkg::byte_class_t data_o
);

  ttip_pkg::byte_class_t              mem_q [ttip_pkg::QueueDepth];
  logic [ttip_pkg::QueueAw-1:0]       wr_q;
  logic [ttip_pkg::QueueAw-1:0]       rd_q;
  logic [ttip_pkg::QueueAw:0]         cnt_q;

  assign full_o  = (cnt_q == (ttip_pkg::QueueAw+1)'(ttip_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + ttip_pkg::QueueAw'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + ttip_pkg::QueueAw'(1);
      end
      cnt_q <= cnt_q + (ttip_pkg::QueueAw+1)'(push_i) - (ttip_pkg::QueueAw+1)'(pop_i);
    end
  end

endmodule

// File: rtl/ttip_back.sv
module ttip_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  ttip_pkg::byte_class_t        q_data_i,
  output logic                         q_pop_o,
  input  logic [ttip_pkg::BaseW-1:0]   number_base_i,
  output logic                         sum_valid_o,
  input  logic                         sum_ready_i,
  output ttip_pkg::slice_sum_t         sum_o
);

  localparam int unsigned ProdW = ttip_pkg::AccW + ttip_pkg::BaseW + 1;
  localparam logic [ttip_pkg::CountW:0] MaxLenW = (ttip_pkg::CountW+1)'(ttip_pkg::MaxLen);

  typedef enum logic [2:0] {
    PhWs,
    PhStart,
    PhZero,
    PhZx,
    PhDig,
    PhDone
  } phase_e;

  phase_e                        phase_q, ph, ph_d;
  logic [ttip_pkg::AccW-1:0]     acc_q, acc_d;
  logic [ttip_pkg::CountW-1:0]   idx_q, mark_q, mark_d, mark_step;
  logic [ttip_pkg::CountW:0]     idx_inc;
  logic [ttip_pkg::BaseW-1:0]    base_q, base, base_d, td_base;
  logic                          neg_q, neg_d, ovf_q, ovf_d, dig_q, dig_d;
  logic                          sum_v_q;
  ttip_pkg::slice_sum_t          sum_q, sum_d;
  ttip_pkg::byte_class_t         c;
  logic                          take, start, do_take, digit_ok, prod_ovf;
  logic [ProdW-1:0]              prod;

  assign c           = q_data_i;
  assign take        = q_valid_i && (!c.last || !sum_v_q || sum_ready_i);
  assign q_pop_o     = take;
  assign sum_valid_o = sum_v_q;
  assign sum_o       = sum_q;

  always_comb begin
    ph   = phase_q;
    base = base_q;
    if (phase_q == PhWs && idx_q == '0) begin
      base = number_base_i;
      if (base == ttip_pkg::BaseOne || base > ttip_pkg::BaseMax) begin
        ph = PhDone;
      end
    end

    idx_inc   = {1'b0, idx_q} + (ttip_pkg::CountW+1)'(1);
    mark_step = (idx_inc > MaxLenW) ? MaxLenW[ttip_pkg::CountW-1:0]
                                    : idx_inc[ttip_pkg::CountW-1:0];

    unique case (ph)
      PhWs, PhStart: td_base = (base == ttip_pkg::BaseAuto) ? ttip_pkg::BaseDec : base;
      PhZero:        td_base = (base == ttip_pkg::BaseAuto) ? ttip_pkg::BaseOct : base;
      PhZx:          td_base = ttip_pkg::BaseHex;
      default:       td_base = base;
    endcase

    prod     = ProdW'(acc_q) * ProdW'(td_base) + ProdW'(c.digit);
    prod_ovf = |prod[ProdW-1:ttip_pkg::AccW];
    digit_ok = (td_base >= ttip_pkg::BaseMin) && (td_base <= ttip_pkg::BaseMax)
               && (c.digit < td_base);

    ph_d    = ph;
    base_d  = base;
    acc_d   = acc_q;
    mark_d  = mark_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    dig_d   = dig_q;
    start   = 1'b0;
    do_take = 1'b0;

    unique case (ph)
      PhWs: begin
        if (c.is_space) begin
          ph_d = PhWs;
        end else if (c.is_minus || c.is_plus) begin
          neg_d = c.is_minus;
          ph_d  = PhStart;
        end else begin
          start = 1'b1;
        end
      end
      PhStart: start = 1'b1;
      PhZero: begin
        if (c.is_x) begin
          ph_d = PhZx;
        end else begin
          base_d  = td_base;
          dig_d   = 1'b1;
          do_take = 1'b1;
        end
      end
      PhZx: begin
        if (c.digit < ttip_pkg::HexLimit) begin
          base_d  = ttip_pkg::BaseHex;
          do_take = 1'b1;
        end else begin
          dig_d = 1'b1;
          ph_d  = PhDone;
        end
      end
      PhDig: do_take = 1'b1;
      default: ph_d = ph;
    endcase

    if (start) begin
      if ((base == ttip_pkg::BaseAuto || base == ttip_pkg::BaseHex) && c.is_zero) begin
        mark_d = mark_step;
        ph_d   = PhZero;
      end else begin
        base_d  = td_base;
        do_take = 1'b1;
      end
    end

    if (do_take) begin
      if (!digit_ok) begin
        ph_d = PhDone;
      end else begin
        if (prod_ovf) begin
          ovf_d = 1'b1;
        end else begin
          acc_d = prod[ttip_pkg::AccW-1:0];
        end
        dig_d  = 1'b1;
        mark_d = mark_step;
        ph_d   = PhDig;
      end
    end

    if (ph_d == PhZero || ph_d == PhZx) begin
      sum_d.found = 1'b1;
    end else begin
      sum_d.found = dig_d;
    end
    sum_d.value = '0;
    sum_d.used  = '0;
    sum_d.neg   = 1'b0;
    sum_d.ovf   = 1'b0;
    if (sum_d.found) begin
      sum_d.value = ovf_d ? '1 : acc_d;
      sum_d.used  = mark_d;
      sum_d.neg   = neg_d;
      sum_d.ovf   = ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhWs;
      acc_q   <= '0;
      idx_q   <= '0;
      mark_q  <= '0;
      base_q  <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      dig_q   <= 1'b0;
      sum_v_q <= 1'b0;
      sum_q   <= '0;
    end else begin
      if (sum_ready_i) begin
        sum_v_q <= 1'b0;
      end
      if (take) begin
        if (c.last) begin
          phase_q <= PhWs;
          acc_q   <= '0;
          idx_q   <= '0;
          mark_q  <= '0;
          base_q  <= '0;
          neg_q   <= 1'b0;
          ovf_q   <= 1'b0;
          dig_q   <= 1'b0;
          sum_v_q <= 1'b1;
          sum_q   <= sum_d;
        end else begin
          phase_q <= ph_d;
          acc_q   <= acc_d;
          idx_q   <= mark_step;
          mark_q  <= mark_d;
          base_q  <= base_d;
          neg_q   <= neg_d;
          ovf_q   <= ovf_d;
          dig_q   <= dig_d;
        end
      end
    end
  end

endmodule

// File: rtl/ttip_result.sv
module ttip_result (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        sum_valid_i,
  output logic                        sum_ready_o,
  input  ttip_pkg::slice_sum_t        sum_i,
  input  logic [ttip_pkg::ModeW-1:0]  mode_i,
  input  logic [ttip_pkg::AccW-1:0]   max_value_i,
  input  logic [ttip_pkg::AccW-1:0]   max_plus1_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ttip_pkg::out_word_t         out_word_o
);

  logic                          c_v_q, out_v_q;
  logic                          out_free, c_free;
  logic [ttip_pkg::AccW-1:0]     lim, val_d, val_q;
  logic                          range_d, negate_d, negate_q;
  ttip_pkg::slice_sum_t          sum_q;
  logic                          range_q;
  ttip_pkg::out_word_t           out_q;

  assign out_free    = !out_v_q || out_ready_i;
  assign c_free      = !c_v_q || out_free;
  assign sum_ready_o = c_free;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  always_comb begin
    lim      = sum_i.neg ? max_plus1_i : max_value_i;
    val_d    = sum_i.value;
    range_d  = 1'b0;
    negate_d = 1'b0;
    if (mode_i == ttip_pkg::ModeSigned) begin
      range_d  = sum_i.ovf || (sum_i.value > lim);
      val_d    = range_d ? lim : sum_i.value;
      negate_d = sum_i.neg;
    end else if (mode_i == ttip_pkg::ModeUnsigned) begin
      range_d  = sum_i.ovf || (sum_i.value > max_value_i);
      val_d    = range_d ? max_value_i : sum_i.value;
      negate_d = sum_i.neg && !range_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q    <= 1'b0;
      out_v_q  <= 1'b0;
      val_q    <= '0;
      negate_q <= 1'b0;
      range_q  <= 1'b0;
      sum_q    <= '0;
      out_q    <= '0;
    end else begin
      if (c_free) begin
        c_v_q <= sum_valid_i;
        if (sum_valid_i) begin
          val_q    <= val_d;
          negate_q <= negate_d;
          range_q  <= range_d;
          sum_q    <= sum_i;
        end
      end
      if (out_free) begin
        out_v_q <= c_v_q;
        if (c_v_q) begin
          out_q.number_out   <= negate_q ? ('0 - val_q) : val_q;
          out_q.bytes_used   <= sum_q.used;
          out_q.is_negative  <= sum_q.neg;
          out_q.did_overflow <= sum_q.ovf;
          out_q.range_error  <= range_q;
          out_q.found_digits <= sum_q.found;
        end
      end
    end
  end

endmodule

// File: rtl/text_to_integer_parser.sv
// channel  | handshake                 | word
// ---------+---------------------------+-----------------------------------------
// in       | in_valid_i / in_ready_o   | in_word_i: one text byte, slice_end flag
// out      | out_valid_o / out_ready_i | out_word_o: one result per slice
// cfg      | cfg_we_i (no wait)        | cfg_idx_i selects, cfg_data_i holds value
//
// Takes one byte every cycle while the queue is not full; the parse step is
// one 64x6 multiply-add per byte. A slice's result passes the queue, the parse
// sum register, clamp compare and negate, then holds until taken.
// The four-entry queue between classifier and parser absorbs output stalls.
// Reset is asynchronous, active low, and needs no clearing pass.
module text_to_integer_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ttip_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ttip_pkg::AccW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ttip_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ttip_pkg::out_word_t           out_word_o
);

  logic [ttip_pkg::BaseW-1:0]  number_base_q;
  logic [ttip_pkg::ModeW-1:0]  result_mode_q;
  logic [ttip_pkg::AccW-1:0]   max_value_q;
  logic [ttip_pkg::AccW-1:0]   max_plus1_q;

  ttip_pkg::byte_class_t       fr_class, q_data;
  logic                        push, full, q_valid, q_pop;
  ttip_pkg::slice_sum_t        sum;
  logic                        sum_valid, sum_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= ttip_pkg::BaseDec;
      result_mode_q <= ttip_pkg::ModeRaw;
      max_value_q   <= ttip_pkg::MaxValueRst;
      max_plus1_q   <= ttip_pkg::MaxValueRst + ttip_pkg::AccW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttip_pkg::CfgNumberBase: number_base_q <= cfg_data_i[ttip_pkg::BaseW-1:0];
        ttip_pkg::CfgResultMode: result_mode_q <= cfg_data_i[ttip_pkg::ModeW-1:0];
        ttip_pkg::CfgMaxValue: begin
          max_value_q <= cfg_data_i;
          max_plus1_q <= cfg_data_i + ttip_pkg::AccW'(1);
        end
        default: max_value_q <= max_value_q;
      endcase
    end
  end

  ttip_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .full_i     (full),
    .push_o     (push),
    .class_o    (fr_class)
  );

  ttip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fr_class),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  ttip_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .number_base_i (number_base_q),
    .sum_valid_o   (sum_valid),
    .sum_ready_i   (sum_ready),
    .sum_o         (sum)
  );

  ttip_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sum_ready_o (sum_ready),
    .sum_i       (sum),
    .mode_i      (result_mode_q),
    .max_value_i (max_value_q),
    .max_plus1_i (max_plus1_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// File: rtl/ttip_checker.sv
module ttip_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ttip_pkg::out_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_word_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  a_empty_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.found_digits |->
      out_word_o.number_out == '0 && out_word_o.bytes_used == '0 &&
      !out_word_o.is_negative && !out_word_o.did_overflow && !out_word_o.range_error)
    else $error("empty parse carries nonzero fields");

  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.found_digits |-> out_word_o.bytes_used != '0)
    else $error("digits found but no bytes consumed");

  a_range_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.range_error |-> out_word_o.found_digits)
    else $error("range error without digits");

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

// File: bench/parse_checker.sv
`timescale 1ns / 1ps

module parse_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ttip_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ttip_pkg::AccW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  ttip_pkg::in_word_t            in_word_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  ttip_pkg::out_word_t           out_word_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import ttip_pkg::*;

  typedef enum logic [2:0] {
    SkipSpace,
    AfterSign,
    LeadZero,
    AfterPrefix,
    InDigits,
    Finished
  } parse_phase_e;

  parse_phase_e      phase;
  logic [AccW-1:0]   acc;
  logic [CountW-1:0] pos;
  logic [CountW-1:0] mark;
  logic [BaseW-1:0]  base_now;
  logic              minus;
  logic              ovf;
  logic              got_digit;

  logic [BaseW-1:0]  reg_base;
  logic [ModeW-1:0]  reg_mode;
  logic [AccW-1:0]   reg_max;

  out_word_t         awaited_results[$];
  int                mismatches;

  function automatic logic [DigitW-1:0] char_weight(logic [7:0] b);
    logic [7:0] lc;
    lc = b | 8'h20;
    if (b >= "0" && b <= "9") return DigitW'(b - "0");
    if (lc >= "a" && lc <= "z") return DigitW'(lc - "a") + DigitW'(10);
    return NotDigit;
  endfunction

  function automatic logic [CountW-1:0] bump(logic [CountW-1:0] n);
    return (n >= CountW'(MaxLen)) ? CountW'(MaxLen) : n + 1'b1;
  endfunction

  task automatic clear_slice();
    phase     = SkipSpace;
    acc       = '0;
    pos       = '0;
    mark      = '0;
    base_now  = '0;
    minus     = 1'b0;
    ovf       = 1'b0;
    got_digit = 1'b0;
  endtask

  task automatic accept_digit(logic [7:0] b);
    logic [DigitW-1:0] d;
    logic [AccW-1:0]   wide_base;
    logic [AccW-1:0]   lim;
    logic [AccW-1:0]   lim_d;
    d = char_weight(b);
    wide_base = AccW'(base_now);
    if (base_now < BaseMin || base_now > BaseMax || AccW'(d) >= wide_base) begin
      phase = Finished;
      return;
    end
    lim   = {AccW{1'b1}} / wide_base;
    lim_d = {AccW{1'b1}} % wide_base;
    if (acc > lim || (acc == lim && AccW'(d) > lim_d)) begin
      ovf = 1'b1;
    end else begin
      acc = acc * wide_base + AccW'(d);
    end
    got_digit = 1'b1;
    mark      = bump(pos);
    phase     = InDigits;
  endtask

  // confirm a pending leading zero; an auto radix becomes octal
  task automatic zero_digit();
    if (base_now == BaseAuto) base_now = BaseOct;
    acc       = '0;
    got_digit = 1'b1;
  endtask

  task automatic begin_number(logic [7:0] b);
    if ((base_now == BaseAuto || base_now == BaseHex) && b == "0") begin
      mark  = bump(pos);
      phase = LeadZero;
    end else begin
      if (base_now == BaseAuto) base_now = BaseDec;
      accept_digit(b);
    end
  endtask

  task automatic advance_parse(in_word_t w);
    out_word_t       res;
    logic [AccW-1:0] v;
    logic [AccW-1:0] lim;
    logic [7:0]      b;
    b = w.text_byte;
    if (phase == SkipSpace && pos == '0) begin
      base_now = reg_base;
      if (base_now == BaseOne || base_now > BaseMax) phase = Finished;
    end
    case (phase)
      SkipSpace: begin
        if (b == "-" || b == "+") begin
          minus = (b == "-");
          phase = AfterSign;
        end else if (!(b == " " || (b >= 8'd9 && b <= 8'd13))) begin
          begin_number(b);
        end
      end
      AfterSign: begin_number(b);
      LeadZero: begin
        if ((b | 8'h20) == "x") begin
          phase = AfterPrefix;
        end else begin
          zero_digit();
          phase = InDigits;
          accept_digit(b);
        end
      end
      AfterPrefix: begin
        if (char_weight(b) < HexLimit) begin
          base_now = BaseHex;
          accept_digit(b);
        end else begin
          zero_digit();
          phase = Finished;
        end
      end
      InDigits: accept_digit(b);
      default: ;
    endcase
    if (!w.slice_end) begin
      pos = bump(pos);
      return;
    end
    if (phase == LeadZero || phase == AfterPrefix) zero_digit();
    res = '0;
    if (got_digit) begin
      v = ovf ? {AccW{1'b1}} : acc;
      if (reg_mode == ModeSigned) begin
        lim = minus ? reg_max + 1'b1 : reg_max;
        if (ovf || v > lim) begin
          res.range_error = 1'b1;
          v = lim;
        end
        if (minus) v = -v;
      end else if (reg_mode == ModeUnsigned) begin
        if (ovf || v > reg_max) begin
          res.range_error = 1'b1;
          v = reg_max;
        end else if (minus) begin
          v = -v;
        end
      end
      res.number_out   = v;
      res.bytes_used   = mark;
      res.is_negative  = minus;
      res.did_overflow = ovf;
      res.found_digits = 1'b1;
    end
    awaited_results.push_back(res);
    clear_slice();
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      reg_base = BaseDec;
      reg_mode = ModeRaw;
      reg_max  = MaxValueRst;
      clear_slice();
      awaited_results.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgNumberBase: reg_base = cfg_data_i[BaseW-1:0];
          CfgResultMode: reg_mode = cfg_data_i[ModeW-1:0];
          CfgMaxValue:   reg_max  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) advance_parse(in_word_i);
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: result with none expected, number_out %h bytes_used %h",
                   $time, out_word_i.number_out, out_word_i.bytes_used);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("number_out", want.number_out, out_word_i.number_out);
          compare_field("bytes_used", 64'(want.bytes_used), 64'(out_word_i.bytes_used));
          compare_field("is_negative", 64'(want.is_negative), 64'(out_word_i.is_negative));
          compare_field("did_overflow", 64'(want.did_overflow),
                        64'(out_word_i.did_overflow));
          compare_field("range_error", 64'(want.range_error), 64'(out_word_i.range_error));
          compare_field("found_digits", 64'(want.found_digits),
                        64'(out_word_i.found_digits));
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ttip_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare      = CfgIdxW'(3);
  localparam logic [ModeW-1:0]   ModeSpare     = ModeW'(3);
  localparam logic [BaseW-1:0]   BaseBad       = '1;
  localparam int                 RandomWords   = 1750;
  localparam int                 CycleLimit    = 600000;
  localparam int                 SqueezeCycles = 300;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx  = '0;
  logic [AccW-1:0]   cfg_data  = '0;
  logic              in_valid  = 1'b0;
  in_word_t          in_word   = '0;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  out_word_t         out_word;

  int fail_count;
  int pending;
  int cycles       = 0;
  int tx_quiet     = 0;
  int rx_quiet     = 0;
  int squeeze_req  = 0;
  int squeeze_done = 0;

  text_to_integer_parser dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  parse_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet = $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return 8'(d) + "0";
    return 8'(d - 10) + ($urandom_range(0, 1) ? "a" : "A");
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= {b, last};
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // drain: hold the input idle until every result is back, then settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(logic [BaseW-1:0] base, logic [ModeW-1:0] mode,
                            logic [AccW-1:0] maxv);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgNumberBase;
    cfg_data <= AccW'(base);
    @(posedge clk);
    cfg_idx  <= CfgResultMode;
    cfg_data <= AccW'(mode);
    @(posedge clk);
    cfg_idx  <= CfgMaxValue;
    cfg_data <= maxv;
    @(posedge clk);
    cfg_idx  <= CfgSpare;
    cfg_data <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : receiver
    int gap;
    wait (rst_n);
    forever begin
      if (squeeze_req != squeeze_done) begin
        out_ready <= 1'b0;
        repeat (SqueezeCycles) @(posedge clk);
        squeeze_done = squeeze_done + 1;
      end
      gap = draw_gap(rx_quiet);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : stimulus
    logic [7:0]        text_q[$];
    logic [7:0]        digit_q[$];
    logic [BaseW-1:0]  nb;
    logic [ModeW-1:0]  nm;
    logic [AccW-1:0]   nv;
    logic [AccW-1:0]   val;
    int                phase_no;
    int                phase_words;
    int                budget;
    int                counted;
    int                eff;
    int                ws;
    int                n;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text(" \t-42x");
    send_text("+");
    wait_idle();
    set_config(BaseAuto, ModeSigned, 64'd100);
    send_text("0x1Fz");
    send_text("-0xg");
    send_text("0x");
    send_text("017");
    send_text("-200");

    counted  = 0;
    phase_no = 0;
    while (counted < RandomWords) begin
      wait_idle();
      nv = {$urandom, $urandom} >> $urandom_range(0, 63);
      case (phase_no)
        0: begin
          nb = BaseMin;
          nm = ModeSpare;
          nv = '0;
        end
        1: begin
          nb = BaseMax;
          nm = ModeSigned;
          nv = '1;
        end
        2: begin
          nb = BaseOne;
          nm = ModeUnsigned;
        end
        3: begin
          nb = BaseAuto;
          nm = ModeUnsigned;
        end
        4: begin
          nb = BaseHex;
          nm = ModeSigned;
          nv = MaxValueRst;
        end
        5: begin
          nb = BaseBad;
          nm = ModeRaw;
        end
        6: begin
          nb = BaseAuto;
          nm = ModeSigned;
          nv = '0;
        end
        default: begin
          case ($urandom_range(0, 5))
            0: nb = BaseAuto;
            1: nb = BaseOct;
            2: nb = BaseDec;
            3: nb = BaseHex;
            default: nb = BaseW'($urandom_range(0, 63));
          endcase
          nm = ModeW'($urandom_range(0, 3));
        end
      endcase
      set_config(nb, nm, nv);
      if (phase_no == 1 || phase_no == 7) squeeze_req = squeeze_req + 1;
      budget = (nb == BaseOne || nb == BaseBad) ? 40 : 150;
      phase_words = 0;
      while (phase_words < budget && counted < RandomWords) begin
        text_q.delete();
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(0, 3)) begin
            ws = $urandom_range(8, 13);
            text_q.push_back(ws == 8 ? " " : 8'(ws));
          end
          case ($urandom_range(0, 3))
            0: text_q.push_back("-");
            1: text_q.push_back("+");
            default: ;
          endcase
          eff = (nb >= BaseMin && nb <= BaseMax) ? int'(nb) : 10;
          if (nb == BaseAuto || nb == BaseHex) begin
            case ($urandom_range(0, 5))
              0, 1: begin
                text_q.push_back("0");
                text_q.push_back($urandom_range(0, 1) ? "x" : "X");
                eff = 16;
              end
              2: begin
                text_q.push_back("0");
                eff = (nb == BaseAuto) ? 8 : 16;
              end
              default: ;
            endcase
          end
          digit_q.delete();
          case ($urandom_range(0, 7))
            0, 1: begin
              case ($urandom_range(0, 2))
                0: val = {AccW{1'b1}} - AccW'($urandom_range(0, 2));
                1: val = nv + AccW'($urandom_range(0, 2)) - 1'b1;
                default: val = {$urandom, $urandom} >> $urandom_range(0, 63);
              endcase
              do begin
                digit_q.push_front(digit_char(int'(val % AccW'(eff))));
                val = val / AccW'(eff);
              end while (val != 0);
              if ($urandom_range(0, 2) == 0) begin
                digit_q.push_back(digit_char($urandom_range(0, eff - 1)));
              end
            end
            2: begin
              repeat ($urandom_range(15, 70)) begin
                digit_q.push_back(digit_char($urandom_range(0, eff - 1)));
              end
            end
            default: begin
              repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 7) == 0) begin
                  digit_q.push_back(8'($urandom_range(0, 255)));
                end else begin
                  digit_q.push_back(digit_char($urandom_range(0, eff - 1)));
                end
              end
            end
          endcase
          foreach (digit_q[k]) text_q.push_back(digit_q[k]);
        end
        n = text_q.size();
        repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(0, 255)));
        foreach (text_q[k]) send_byte(text_q[k], k == text_q.size() - 1);
        phase_words += n;
        counted += n;
      end
      phase_no++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
